// File: src/wopi_pkg.sv
// ----------------------------------------------------------------------------
// wopi_pkg
// Shared types, constants and the arctangent table of the odometry integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package wopi_pkg;

  localparam int unsigned TIME_W           = 48;
  localparam int unsigned POSE_W           = 32;
  localparam int unsigned CFG_W            = 32;
  localparam int unsigned WIDE_W           = 64;
  localparam int unsigned CORDIC_W         = 34;
  localparam int unsigned ATAN_IDX_W       = 5;
  localparam int unsigned SHIFT_W          = 6;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned PULSE_BITS_DEF   = 16;

  localparam logic [CFG_W-1:0]           MPP_RESET   = 32'd468497;
  localparam logic [CFG_W-1:0]           ITW_RESET   = 32'd33554432;
  localparam logic signed [WIDE_W-1:0]   BAM_PER_RAD = 64'sd683565276;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [WIDE_W-1:0]   ONE_Q30     = 64'sd1073741824;
  // reciprocals of 6, 120 and 5040, exact for the series term ranges
  localparam logic signed [WIDE_W-1:0]   SINC_RCP_A  = 64'sd357913942;
  localparam logic signed [WIDE_W-1:0]   SINC_RCP_B  = 64'sd71582789;
  localparam logic signed [WIDE_W-1:0]   SINC_RCP_C  = 64'sd27269634;
  localparam logic signed [WIDE_W-1:0]   SMALL_LIM   = 64'sd32768;
  localparam logic [POSE_W-1:0]          QUARTER_TURN = 32'h4000_0000;
  localparam logic [POSE_W-1:0]          HALF_TURN    = 32'h8000_0000;

  localparam logic [SHIFT_W-1:0] SH_DIST  = 6'd16;
  localparam logic [SHIFT_W-1:0] SH_TURN  = 6'd24;
  localparam logic [SHIFT_W-1:0] SH_BAM   = 6'd16;
  localparam logic [SHIFT_W-1:0] SH_SQ    = 6'd2;
  localparam logic [SHIFT_W-1:0] SH_Q30   = 6'd30;
  localparam logic [SHIFT_W-1:0] SH_RCP_A = 6'd31;
  localparam logic [SHIFT_W-1:0] SH_RCP_B = 6'd33;
  localparam logic [SHIFT_W-1:0] SH_RCP_C = 6'd37;
  localparam logic [SHIFT_W-1:0] SH_NONE  = 6'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MPP = 1'b0,
    REG_ITW = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_MUL_DL,
    OP_MUL_DR,
    OP_SUMDIFF,
    OP_MUL_TURN,
    OP_HALF,
    OP_BAM_HALF,
    OP_BAM_TURN,
    OP_MUL_SQ,
    OP_MUL_S2,
    OP_MUL_S3,
    OP_DIV_A,
    OP_DIV_B,
    OP_DIV_C,
    OP_CORDIC_H,
    OP_DIV_SINC,
    OP_CORDIC_P,
    OP_MUL_STEP,
    OP_MUL_DX,
    OP_MUL_DY,
    OP_EMIT
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic small_turn;
    logic out_free;
  } status_t;

  function automatic logic [POSE_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic [POSE_W-1:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      5'd31: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/wopi_mdu.sv
// ----------------------------------------------------------------------------
// wopi_mdu
// Shared multi-cycle multiply/shift and signed divide unit (64-bit operands).
// ----------------------------------------------------------------------------
`default_nettype none

module wopi_mdu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               is_div_i,
  input  logic signed [wopi_pkg::WIDE_W-1:0] a_i,
  input  logic signed [wopi_pkg::WIDE_W-1:0] b_i,
  input  logic [wopi_pkg::SHIFT_W-1:0]       shift_i,
  output logic                               done_o,
  output logic signed [wopi_pkg::WIDE_W-1:0] result_o
);
  import wopi_pkg::*;

  localparam int unsigned DIV_STEPS = WIDE_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned PROD_W    = 2 * WIDE_W;
  localparam int unsigned LIMB_W    = WIDE_W / 2;

  typedef enum logic [1:0] {P_IDLE, P_MUL, P_DIV, P_FIN} phase_e;

  phase_e                  phase_q;
  logic                    div_q;
  logic                    neg_q;
  logic [SHIFT_W-1:0]      sh_q;
  logic [WIDE_W-1:0]       ma_q, mb_q;
  logic [PROD_W-1:0]       acc_q;
  logic [WIDE_W:0]         rem_q;
  logic [1:0]              pcnt_q;
  logic [DCNT_W-1:0]       dcnt_q;
  logic                    done_q;
  logic signed [WIDE_W-1:0] res_q;

  logic [WIDE_W-1:0]  mag_a, mag_b;
  logic [LIMB_W-1:0]  limb_a, limb_b;
  logic [WIDE_W-1:0]  pp;
  logic [1:0]         pos;
  logic [PROD_W-1:0]  pp_sh;
  logic [PROD_W-1:0]  prod_s;
  logic signed [PROD_W-1:0] prod_sh;
  logic [WIDE_W:0]    rem_sh;
  logic               fits;

  assign mag_a  = a_i[WIDE_W-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b  = b_i[WIDE_W-1] ? (~b_i + 1'b1) : b_i;
  assign limb_a = pcnt_q[1] ? ma_q[WIDE_W-1:LIMB_W] : ma_q[LIMB_W-1:0];
  assign limb_b = pcnt_q[0] ? mb_q[WIDE_W-1:LIMB_W] : mb_q[LIMB_W-1:0];
  assign pp     = limb_a * limb_b;
  assign pos    = {1'b0, pcnt_q[1]} + {1'b0, pcnt_q[0]};
  assign pp_sh  = {{WIDE_W{1'b0}}, pp} << {pos, 5'd0};
  assign prod_s = neg_q ? (~acc_q + 1'b1) : acc_q;
  assign prod_sh = $signed(prod_s) >>> sh_q;
  assign rem_sh = {rem_q[WIDE_W-1:0], ma_q[WIDE_W-1]};
  assign fits   = rem_sh >= {1'b0, mb_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      done_q  <= 1'b0;
      div_q   <= 1'b0;
      neg_q   <= 1'b0;
      sh_q    <= '0;
      pcnt_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        P_IDLE: begin
          if (start_i) begin
            ma_q    <= mag_a;
            mb_q    <= mag_b;
            neg_q   <= a_i[WIDE_W-1] ^ b_i[WIDE_W-1];
            sh_q    <= shift_i;
            div_q   <= is_div_i;
            acc_q   <= '0;
            rem_q   <= '0;
            pcnt_q  <= '0;
            dcnt_q  <= '0;
            phase_q <= is_div_i ? P_DIV : P_MUL;
          end
        end
        P_MUL: begin
          acc_q  <= acc_q + pp_sh;
          pcnt_q <= pcnt_q + 2'd1;
          if (pcnt_q == 2'd3) phase_q <= P_FIN;
        end
        P_DIV: begin
          rem_q  <= fits ? (rem_sh - {1'b0, mb_q}) : rem_sh;
          ma_q   <= {ma_q[WIDE_W-2:0], fits};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) phase_q <= P_FIN;
        end
        P_FIN: begin
          if (div_q) begin
            res_q <= neg_q ? $signed(~ma_q + 1'b1) : $signed(ma_q);
          end else begin
            res_q <= prod_sh[WIDE_W-1:0];
          end
          done_q  <= 1'b1;
          phase_q <= P_IDLE;
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// File: src/wopi_cordic.sv
// ----------------------------------------------------------------------------
// wopi_cordic
// Iterative rotation-mode CORDIC giving sine and cosine of a binary angle.
// ----------------------------------------------------------------------------
`default_nettype none

module wopi_cordic #(
  parameter int unsigned CORDIC_STEPS = wopi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [wopi_pkg::POSE_W-1:0]          angle_i,
  output logic                                 done_o,
  output logic signed [wopi_pkg::CORDIC_W-1:0] sin_o,
  output logic signed [wopi_pkg::CORDIC_W-1:0] cos_o
);
  import wopi_pkg::*;

  localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(CORDIC_STEPS - 1);

  logic                       busy_q;
  logic                       done_q;
  logic                       flip_q;
  logic [ATAN_IDX_W-1:0]      i_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic signed [CORDIC_W-1:0] sin_q, cos_q;

  logic [POSE_W-1:0]          turned;
  logic                       flip;
  logic [POSE_W-1:0]          ua;
  logic signed [CORDIC_W-1:0] xs, ys, at, xn, yn, zn;

  assign turned = angle_i + QUARTER_TURN;
  assign flip   = turned[POSE_W-1];
  assign ua     = flip ? (angle_i + HALF_TURN) : angle_i;
  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign at     = $signed({2'b00, atan_lut(i_q)});

  always_comb begin
    if (!z_q[CORDIC_W-1]) begin
      xn = x_q - ys;
      yn = y_q + xs;
      zn = z_q - at;
    end else begin
      xn = x_q + ys;
      yn = y_q - xs;
      zn = z_q + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          busy_q <= 1'b1;
          flip_q <= flip;
          i_q    <= '0;
          x_q    <= CORDIC_GAIN;
          y_q    <= '0;
          z_q    <= $signed({{2{ua[POSE_W-1]}}, ua});
        end
      end else begin
        x_q <= xn;
        y_q <= yn;
        z_q <= zn;
        i_q <= i_q + 1'b1;
        if (i_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          cos_q  <= flip_q ? -xn : xn;
          sin_q  <= flip_q ? -yn : yn;
        end
      end
    end
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

`default_nettype wire

// File: src/wopi_dp.sv
// ----------------------------------------------------------------------------
// wopi_dp
// Datapath: configuration, pose state, intermediates and the shared units.
// ----------------------------------------------------------------------------
`default_nettype none

module wopi_dp #(
  parameter int unsigned PULSE_BITS   = wopi_pkg::PULSE_BITS_DEF,
  parameter int unsigned CORDIC_STEPS = wopi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wopi_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wopi_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_accept_i,
  input  logic [wopi_pkg::TIME_W-1:0]         in_time_i,
  input  logic signed [PULSE_BITS-1:0]        in_left_i,
  input  logic signed [PULSE_BITS-1:0]        in_right_i,
  input  wopi_pkg::cmd_t                      cmd_i,
  output wopi_pkg::status_t                   status_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wopi_pkg::TIME_W-1:0]         out_time_o,
  output logic signed [wopi_pkg::POSE_W-1:0]  out_x_o,
  output logic signed [wopi_pkg::POSE_W-1:0]  out_y_o,
  output logic [wopi_pkg::POSE_W-1:0]         out_heading_o
);
  import wopi_pkg::*;

  logic [CFG_W-1:0]          mpp_q, itw_q;
  logic [TIME_W-1:0]         time_q;
  logic signed [WIDE_W-1:0]  lp_q, rp_q, dl_q, dr_q, arc_q, diff_q, turn_q, half_q;
  logic signed [WIDE_W-1:0]  sq_q, s2_q, s3_q, sinc_q, sn_q, cs_q, step_q;
  logic [POSE_W-1:0]         hbam_q, tbam_q;
  logic [POSE_W-1:0]         pose_x_q, pose_y_q, pose_h_q;
  op_e                       op_q;
  logic                      single_done_q;
  logic                      out_valid_q;
  logic [TIME_W-1:0]         out_time_q;
  logic [POSE_W-1:0]         out_x_q, out_y_q, out_h_q;

  logic                      mdu_go, mdu_div, cor_go, single_go;
  logic signed [WIDE_W-1:0]  opa, opb;
  logic [SHIFT_W-1:0]        opsh;
  logic [POSE_W-1:0]         cor_angle;
  logic                      mdu_done, cor_done;
  logic signed [WIDE_W-1:0]  mdu_res;
  logic signed [CORDIC_W-1:0] cor_sin, cor_cos;
  logic [POSE_W-1:0]         new_heading;

  always_comb begin
    mdu_go    = 1'b0;
    mdu_div   = 1'b0;
    cor_go    = 1'b0;
    single_go = 1'b0;
    opa       = '0;
    opb       = '0;
    opsh      = SH_NONE;
    cor_angle = hbam_q;
    unique case (cmd_i.op)
      OP_MUL_DL:   begin mdu_go = 1'b1; opa = lp_q; opb = $signed({32'd0, mpp_q});
                         opsh = SH_DIST; end
      OP_MUL_DR:   begin mdu_go = 1'b1; opa = rp_q; opb = $signed({32'd0, mpp_q});
                         opsh = SH_DIST; end
      OP_MUL_TURN: begin mdu_go = 1'b1; opa = diff_q; opb = $signed({32'd0, itw_q});
                         opsh = SH_TURN; end
      OP_BAM_HALF: begin mdu_go = 1'b1; opa = half_q; opb = BAM_PER_RAD; opsh = SH_BAM; end
      OP_BAM_TURN: begin mdu_go = 1'b1; opa = turn_q; opb = BAM_PER_RAD; opsh = SH_BAM; end
      OP_MUL_SQ:   begin mdu_go = 1'b1; opa = half_q; opb = half_q; opsh = SH_SQ; end
      OP_MUL_S2:   begin mdu_go = 1'b1; opa = sq_q; opb = sq_q; opsh = SH_Q30; end
      OP_MUL_S3:   begin mdu_go = 1'b1; opa = s2_q; opb = sq_q; opsh = SH_Q30; end
      OP_MUL_STEP: begin mdu_go = 1'b1; opa = arc_q; opb = sinc_q; opsh = SH_Q30; end
      OP_MUL_DX:   begin mdu_go = 1'b1; opa = step_q; opb = cs_q; opsh = SH_Q30; end
      OP_MUL_DY:   begin mdu_go = 1'b1; opa = step_q; opb = sn_q; opsh = SH_Q30; end
      OP_DIV_A:    begin mdu_go = 1'b1; opa = sq_q; opb = SINC_RCP_A; opsh = SH_RCP_A; end
      OP_DIV_B:    begin mdu_go = 1'b1; opa = s2_q; opb = SINC_RCP_B; opsh = SH_RCP_B; end
      OP_DIV_C:    begin mdu_go = 1'b1; opa = s3_q; opb = SINC_RCP_C; opsh = SH_RCP_C; end
      OP_DIV_SINC: begin mdu_go = 1'b1; mdu_div = 1'b1; opa = sn_q <<< 16; opb = half_q; end
      OP_CORDIC_H: begin cor_go = 1'b1; cor_angle = hbam_q; end
      OP_CORDIC_P: begin cor_go = 1'b1; cor_angle = pose_h_q + hbam_q; end
      OP_SUMDIFF, OP_HALF, OP_EMIT: single_go = 1'b1;
      default: single_go = 1'b1;
    endcase
  end

  wopi_mdu u_mdu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start && mdu_go),
    .is_div_i (mdu_div),
    .a_i      (opa),
    .b_i      (opb),
    .shift_i  (opsh),
    .done_o   (mdu_done),
    .result_o (mdu_res)
  );

  wopi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && cor_go),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  assign new_heading = pose_h_q + tbam_q;

  // config and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpp_q         <= MPP_RESET;
      itw_q         <= ITW_RESET;
      pose_x_q      <= '0;
      pose_y_q      <= '0;
      pose_h_q      <= '0;
      op_q          <= OP_MUL_DL;
      single_done_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      single_done_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_MPP) mpp_q <= cfg_data_i;
        if (cfg_index_i == REG_ITW) itw_q <= cfg_data_i;
      end
      if (cmd_i.start) begin
        op_q <= cmd_i.op;
        if (single_go) single_done_q <= 1'b1;
      end
      if (mdu_done && op_q == OP_MUL_DX) pose_x_q <= pose_x_q + mdu_res[POSE_W-1:0];
      if (mdu_done && op_q == OP_MUL_DY) pose_y_q <= pose_y_q + mdu_res[POSE_W-1:0];
      if (cmd_i.start && cmd_i.op == OP_EMIT) begin
        pose_h_q    <= new_heading;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // intermediates
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      time_q <= in_time_i;
      lp_q   <= WIDE_W'(in_left_i);
      rp_q   <= -(WIDE_W'(in_right_i));
    end
    if (cmd_i.start) begin
      unique case (cmd_i.op)
        OP_SUMDIFF: begin
          arc_q  <= (dr_q + dl_q) >>> 1;
          diff_q <= dr_q - dl_q;
        end
        OP_HALF: half_q <= turn_q >>> 1;
        OP_EMIT: begin
          out_time_q <= time_q;
          out_x_q    <= pose_x_q;
          out_y_q    <= pose_y_q;
          out_h_q    <= new_heading;
        end
        default: ;
      endcase
    end
    if (cor_done) begin
      sn_q <= WIDE_W'(cor_sin);
      cs_q <= WIDE_W'(cor_cos);
    end
    if (mdu_done) begin
      unique case (op_q)
        OP_MUL_DL:   dl_q   <= mdu_res;
        OP_MUL_DR:   dr_q   <= mdu_res;
        OP_MUL_TURN: turn_q <= mdu_res;
        OP_BAM_HALF: hbam_q <= mdu_res[POSE_W-1:0];
        OP_BAM_TURN: tbam_q <= mdu_res[POSE_W-1:0];
        OP_MUL_SQ:   sq_q   <= mdu_res;
        OP_MUL_S2:   s2_q   <= mdu_res;
        OP_MUL_S3:   s3_q   <= mdu_res;
        OP_DIV_A:    sinc_q <= ONE_Q30 - mdu_res;
        OP_DIV_B:    sinc_q <= sinc_q + mdu_res;
        OP_DIV_C:    sinc_q <= sinc_q - mdu_res;
        OP_DIV_SINC: sinc_q <= mdu_res;
        OP_MUL_STEP: step_q <= mdu_res;
        default: ;
      endcase
    end
  end

  assign status_o.done       = single_done_q | mdu_done | cor_done;
  assign status_o.small_turn = (half_q > -SMALL_LIM) && (half_q < SMALL_LIM);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_time_o    = out_time_q;
  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_heading_o = out_h_q;

endmodule

`default_nettype wire

// File: src/wopi_ctrl.sv
// ----------------------------------------------------------------------------
// wopi_ctrl
// Controller: sequences the datapath operations for one encoder sample.
// ----------------------------------------------------------------------------
`default_nettype none

module wopi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_accept_i,
  output logic              in_ready_o,
  output wopi_pkg::cmd_t    cmd_o,
  input  wopi_pkg::status_t status_i
);
  import wopi_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_WAIT_OUT} state_e;

  state_e state_q;
  logic   ready_q;
  logic   start_q;
  op_e    op_q;

  function automatic op_e next_op(input op_e cur, input logic small_turn);
    op_e n;
    unique case (cur)
      OP_MUL_DL:   n = OP_MUL_DR;
      OP_MUL_DR:   n = OP_SUMDIFF;
      OP_SUMDIFF:  n = OP_MUL_TURN;
      OP_MUL_TURN: n = OP_HALF;
      OP_HALF:     n = OP_BAM_HALF;
      OP_BAM_HALF: n = OP_BAM_TURN;
      OP_BAM_TURN: n = small_turn ? OP_MUL_SQ : OP_CORDIC_H;
      OP_MUL_SQ:   n = OP_MUL_S2;
      OP_MUL_S2:   n = OP_MUL_S3;
      OP_MUL_S3:   n = OP_DIV_A;
      OP_DIV_A:    n = OP_DIV_B;
      OP_DIV_B:    n = OP_DIV_C;
      OP_DIV_C:    n = OP_CORDIC_P;
      OP_CORDIC_H: n = OP_DIV_SINC;
      OP_DIV_SINC: n = OP_CORDIC_P;
      OP_CORDIC_P: n = OP_MUL_STEP;
      OP_MUL_STEP: n = OP_MUL_DX;
      OP_MUL_DX:   n = OP_MUL_DY;
      default:     n = OP_EMIT;
    endcase
    return n;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      start_q <= 1'b0;
      op_q    <= OP_MUL_DL;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept_i) begin
            ready_q <= 1'b0;
            start_q <= 1'b1;
            op_q    <= OP_MUL_DL;
            state_q <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          if (status_i.done) begin
            priority if (op_q == OP_EMIT) begin
              ready_q <= 1'b1;
              state_q <= ST_IDLE;
            end else if (op_q == OP_MUL_DY) begin
              state_q <= ST_WAIT_OUT;
            end else begin
              start_q <= 1'b1;
              op_q    <= next_op(op_q, status_i.small_turn);
            end
          end
        end
        ST_WAIT_OUT: begin
          if (status_i.out_free) begin
            start_q <= 1'b1;
            op_q    <= OP_EMIT;
            state_q <= ST_BUSY;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = ready_q;
  assign cmd_o.start = start_q;
  assign cmd_o.op    = op_q;

endmodule

`default_nettype wire

// File: src/wheel_odometry_pose_integrator.sv
// ----------------------------------------------------------------------------
// wheel_odometry_pose_integrator
// Differential-drive odometry: integrates wheel pulse counts into a 2D pose.
// ----------------------------------------------------------------------------
// Input stream s_axis carries one encoder sample per transaction (timestamp,
// left and right pulse counts). Output stream m_axis carries the timestamp and
// the updated pose (x, y in Q16.16 metres, heading as a 32-bit binary angle).
// The cfg channel writes metres_per_pulse (index 0) and inverse_track_width
// (index 1); cfg_ready_o is always high and writes take effect at once.
// One sample is processed at a time; the block is ready for the next sample
// in the cycle after the result becomes valid. The controller runs every
// step one after the other: multiplies of four 32x32 partial products,
// CORDIC rotations and, on the large-turn path, one 64-step division; the
// small-turn series divides by constants through reciprocal multiplies.
// The result sits in an output register: if the receiver stalls, the next
// sample is still accepted and computed, and the block waits only before
// writing a second result. Reset clears the pose to zero and loads the default
// configuration; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_odometry_pose_integrator #(
  parameter int unsigned CORDIC_STEPS = wopi_pkg::CORDIC_STEPS_DEF,
  parameter int unsigned PULSE_BITS   = wopi_pkg::PULSE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wopi_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wopi_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_time, left_pulses, right_pulses, zero pad
  input  logic [((48 + 2 * PULSE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_time, pos_x, pos_y, heading
  output logic [143:0]                      m_axis_tdata
);
  import wopi_pkg::*;

  localparam int unsigned L_LO = TIME_W;
  localparam int unsigned R_LO = TIME_W + PULSE_BITS;

  cmd_t                      cmd;
  status_t                   status;
  logic                      in_ready;
  logic                      in_accept;
  logic [TIME_W-1:0]         out_time;
  logic signed [POSE_W-1:0]  out_x, out_y;
  logic [POSE_W-1:0]         out_h;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = in_ready;
  assign in_accept     = s_axis_tvalid && in_ready;

  wopi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  wopi_dp #(
    .PULSE_BITS   (PULSE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_accept_i   (in_accept),
    .in_time_i     (s_axis_tdata[TIME_W-1:0]),
    .in_left_i     ($signed(s_axis_tdata[L_LO +: PULSE_BITS])),
    .in_right_i    ($signed(s_axis_tdata[R_LO +: PULSE_BITS])),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_time_o    (out_time),
    .out_x_o       (out_x),
    .out_y_o       (out_y),
    .out_heading_o (out_h)
  );

  assign m_axis_tdata = {out_h, out_y, out_x, out_time};

endmodule

`default_nettype wire

// File: dv/wheel_odometry_pose_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_odometry_pose_checker
// Watches the configuration, sample and pose channels of the odometry
// integrator, keeps its own pose and configuration, predicts each pose in
// fixed point and compares it field by field with what the block emits.
// ----------------------------------------------------------------------------

module wheel_odometry_pose_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [wopi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [wopi_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [79:0]                      s_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [143:0]                     m_tdata_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               poses_seen_o,
  output int                               wide_turns_o
);

  // same layout as the pose tdata, out_time lowest
  typedef struct packed {
    logic [31:0] hdg;
    logic [31:0] y;
    logic [31:0] x;
    logic [47:0] stamp;
  } pose_t;

  localparam int STEPS = 24;

  logic [31:0] arctan_bam [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0};

  logic [31:0] dist_scale, turn_scale;
  logic [31:0] cur_x, cur_y, cur_hdg;
  pose_t       pose_q[$];

  function automatic logic signed [63:0] prod_shift(logic signed [63:0] a,
                                                    logic signed [63:0] b, int sh);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p = wa * wb;
    p = p >>> sh;
    return p[63:0];
  endfunction

  function automatic logic [31:0] to_bam(logic signed [63:0] rad);
    logic [63:0] p;
    p = rad * 64'd683565276;
    return p[47:16];
  endfunction

  task automatic rotate(input logic [31:0] ang, output logic signed [63:0] sn,
                        output logic signed [63:0] cs);
    logic [31:0]        ua, tmp;
    logic               flip;
    logic signed [63:0] vx, vy, vz, xs, ys;
    ua = ang;
    tmp = ua + 32'h4000_0000;
    flip = tmp[31];
    if (flip) ua = ua + 32'h8000_0000;
    vz = $signed({{32{ua[31]}}, ua});
    vx = 64'sd652032874;
    vy = 0;
    for (int i = 0; i < STEPS; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vz >= 0) begin
        vx = vx - ys;
        vy = vy + xs;
        vz = vz - $signed({32'd0, arctan_bam[i]});
      end else begin
        vx = vx + ys;
        vy = vy - xs;
        vz = vz + $signed({32'd0, arctan_bam[i]});
      end
    end
    cs = flip ? -vx : vx;
    sn = flip ? -vy : vy;
  endtask

  task automatic advance_pose(input logic [79:0] smp, output pose_t res,
                              output logic wide);
    logic signed [63:0] lp, rp, d_l, d_r, arc, turn, half, sinc, sn, cs, step;
    logic signed [63:0] sq, s2, s3, scale;
    logic [31:0]        half_bam;
    lp = $signed(smp[63:48]);
    rp = -$signed({{48{smp[79]}}, smp[79:64]});
    scale = {32'd0, dist_scale};
    d_l = prod_shift(lp, scale, 16);
    d_r = prod_shift(rp, scale, 16);
    arc = (d_r + d_l) >>> 1;
    turn = prod_shift(d_r - d_l, {32'd0, turn_scale}, 24);
    half = turn >>> 1;
    half_bam = to_bam(half);
    wide = !(half > -64'sd32768 && half < 64'sd32768);
    if (!wide) begin
      sq = (half * half) >>> 2;
      s2 = (sq * sq) >>> 30;
      s3 = (s2 * sq) >>> 30;
      sinc = 64'sd1073741824 - sq / 6 + s2 / 120 - s3 / 5040;
    end else begin
      rotate(half_bam, sn, cs);
      sinc = (sn * 64'sd65536) / half;
    end
    rotate(cur_hdg + half_bam, sn, cs);
    step = prod_shift(arc, sinc, 30);
    cur_x = cur_x + 32'(prod_shift(step, cs, 30));
    cur_y = cur_y + 32'(prod_shift(step, sn, 30));
    cur_hdg = cur_hdg + to_bam(turn);
    res.stamp = smp[47:0];
    res.x = cur_x;
    res.y = cur_y;
    res.hdg = cur_hdg;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t got, want;
    logic  wide;
    if (!rst_ni) begin
      dist_scale = wopi_pkg::MPP_RESET;
      turn_scale = wopi_pkg::ITW_RESET;
      cur_x = '0;
      cur_y = '0;
      cur_hdg = '0;
      pose_q.delete();
      fail_count_o = 0;
      poses_seen_o = 0;
      wide_turns_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i;
        poses_seen_o++;
        if (pose_q.size() == 0) begin
          $error("pose transaction with no sample pending: %h", m_tdata_i);
          fail_count_o++;
        end else begin
          want = pose_q.pop_front();
          if (got.stamp != want.stamp) begin
            $error("out_time: expected %h, got %h", want.stamp, got.stamp);
            fail_count_o++;
          end
          if (got.x != want.x) begin
            $error("pos_x: expected %h, got %h", want.x, got.x);
            fail_count_o++;
          end
          if (got.y != want.y) begin
            $error("pos_y: expected %h, got %h", want.y, got.y);
            fail_count_o++;
          end
          if (got.hdg != want.hdg) begin
            $error("heading: expected %h, got %h", want.hdg, got.hdg);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        advance_pose(s_tdata_i, want, wide);
        if (wide) wide_turns_o++;
        pose_q = {pose_q, want};
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == wopi_pkg::REG_MPP) dist_scale = cfg_data_i;
        else if (cfg_index_i == wopi_pkg::REG_ITW) turn_scale = cfg_data_i;
      end
    end
    pending_o = pose_q.size();
  end

endmodule

// File: dv/wheel_odometry_pose_integrator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_odometry_pose_integrator_tb
// Drives encoder samples and configuration writes into the odometry
// integrator with random gaps and output stalls; a separate checker predicts
// and compares every pose, and this module reports the verdict.
// ----------------------------------------------------------------------------

module wheel_odometry_pose_integrator_tb;

  localparam int CYCLE_LIMIT = 3000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  wopi_pkg::reg_idx_e cfg_index_i = wopi_pkg::REG_MPP;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  int           fail_count, pending, poses_seen, wide_turns;
  int           cycles = 0;
  logic         stall_free = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  wheel_odometry_pose_integrator dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  wheel_odometry_pose_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending),
    .poses_seen_o(poses_seen), .wide_turns_o(wide_turns)
  );

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("wheel_odometry_pose_integrator_tb: done, errors");
      $finish;
    end
  end

  // receiver stalls, with stretches of always-ready
  always @(negedge clk_i) begin
    if (stall_free) m_axis_tready <= 1'b1;
    else if ($urandom_range(0, 99) < 3) m_axis_tready <= 1'b0;
    else if ($urandom_range(0, 9) < 6) m_axis_tready <= 1'b1;
    else m_axis_tready <= 1'b0;
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 499) == 0) stall_free <= ~stall_free;
  end

  task automatic send_sample(input logic [47:0] stamp, input logic [15:0] lft,
                             input logic [15:0] rgt);
    int gap;
    s_axis_tdata <= {rgt, lft, stamp};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input wopi_pkg::reg_idx_e idx, input logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_samples(input int count);
    logic [15:0] lft, rgt;
    int          kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // mirrored right wheel: forward motion has opposite signs
        lft = 16'($urandom_range(0, 1200)) - 16'd300;
        rgt = -lft + 16'($urandom_range(0, 200)) - 16'd100;
      end else if (kind < 9) begin
        lft = 16'($urandom);
        rgt = 16'($urandom);
      end else begin
        lft = 16'($urandom_range(0, 6)) - 16'd3;
        rgt = 16'($urandom_range(0, 6)) - 16'd3;
      end
      send_sample({16'($urandom), 32'($urandom)}, lft, rgt);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: standstill, straight runs, spins, extremes
    send_sample(48'd0, 16'd0, 16'd0);
    send_sample(48'hFFFF_FFFF_FFFF, 16'd100, -16'd100);
    send_sample(48'd1, 16'd100, 16'd100);
    send_sample(48'd2, -16'd100, -16'd100);
    send_sample(48'd3, 16'h7FFF, 16'h7FFF);
    send_sample(48'd4, 16'h8000, 16'h8000);
    send_sample(48'd5, 16'h7FFF, 16'h8000);
    send_sample(48'd6, 16'h8000, 16'h7FFF);
    send_sample(48'd7, 16'd0, 16'h8000);
    send_sample(48'd8, 16'h8000, 16'd0);
    send_sample(48'd9, 16'd4000, -16'd3000);
    send_sample(48'hAAAA_AAAA_AAAA, 16'd1, 16'd0);
    send_sample(48'h5555_5555_5555, 16'd0, -16'd1);
    send_sample(48'd10, 16'hFFFF, 16'hFFFF);
    random_samples(160);

    write_reg(wopi_pkg::REG_MPP, 32'hFFFF_FFFF);
    write_reg(wopi_pkg::REG_ITW, 32'hFFFF_FFFF);
    send_sample(48'd11, 16'h7FFF, 16'h7FFF);
    send_sample(48'd12, 16'h8000, 16'h7FFF);
    random_samples(150);

    write_reg(wopi_pkg::REG_MPP, 32'd0);
    write_reg(wopi_pkg::REG_ITW, 32'd1);
    random_samples(80);

    // zero reciprocal track width: heading frozen
    write_reg(wopi_pkg::REG_MPP, $urandom);
    write_reg(wopi_pkg::REG_ITW, 32'd0);
    random_samples(150);

    write_reg(wopi_pkg::REG_MPP, 32'd1);
    write_reg(wopi_pkg::REG_ITW, 32'd1);
    random_samples(100);

    write_reg(wopi_pkg::REG_MPP, $urandom);
    write_reg(wopi_pkg::REG_ITW, $urandom);
    random_samples(200);

    write_reg(wopi_pkg::REG_MPP, wopi_pkg::MPP_RESET);
    write_reg(wopi_pkg::REG_ITW, wopi_pkg::ITW_RESET);
    random_samples(250);

    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk_i);
    $display("covered %0d poses (%0d with a wide half turn) over 7 settings",
             poses_seen, wide_turns);
    if (fail_count == 0 && pending == 0) begin
      $display("wheel_odometry_pose_integrator_tb: done, clean");
    end else begin
      $display("wheel_odometry_pose_integrator_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/wopi_pkg.sv
src/wopi_mdu.sv
src/wopi_cordic.sv
src/wopi_dp.sv
src/wopi_ctrl.sv
src/wheel_odometry_pose_integrator.sv
dv/wheel_odometry_pose_checker.sv
dv/wheel_odometry_pose_integrator_tb.sv
